FILE: sv/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types and constants of the planar frame transform: rotator word
// widths, the arctangent table in 32-bit turn units and the function codes.
// ----------------------------------------------------------------------------
package pft_pkg;

  // Rotator datapath: Q2.30 coordinates with headroom, 32-bit turn angles
  localparam int COORD_W  = 34;
  localparam int COEF_W   = 32;
  localparam int TURN_W   = 32;
  localparam int ATAN_LEN = 24;

  // 1/K in Q2.30, K the limit gain of the rotator
  localparam logic signed [COORD_W-1:0] INV_GAIN = COORD_W'(652032874);

  // Pipeline depth of the rounded dot product unit
  localparam int DOT_LAT = 3;

  // Function select codes
  localparam logic FUNC_LOCAL_TO_WORLD = 1'b0;
  localparam logic FUNC_WORLD_TO_LOCAL = 1'b1;

  localparam logic [TURN_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Rotator state handed from cell to cell
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [TURN_W-1:0]  z;
  } rot_t;

endpackage

FILE: sv/pft_cordic_cell.sv
// ----------------------------------------------------------------------------
// pft_cordic_cell
// One micro-rotation of the cosine/sine rotator; carries the item's side data.
// ----------------------------------------------------------------------------
module pft_cordic_cell #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  pft_pkg::rot_t       rot_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output pft_pkg::rot_t       rot_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic signed [pft_pkg::COORD_W-1:0] xs, ys;
  pft_pkg::rot_t                      rot_d, rot_q;
  logic                               valid_q;
  logic [SIDE_W-1:0]                  side_q;

  always_comb begin
    xs = rot_i.x >>> IDX;
    ys = rot_i.y >>> IDX;
    if (rot_i.z[pft_pkg::TURN_W-1]) begin
      rot_d.x = rot_i.x + ys;
      rot_d.y = rot_i.y - xs;
      rot_d.z = rot_i.z + pft_pkg::ATAN_TURNS[IDX];
    end else begin
      rot_d.x = rot_i.x - ys;
      rot_d.y = rot_i.y + xs;
      rot_d.z = rot_i.z - pft_pkg::ATAN_TURNS[IDX];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q  <= rot_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;
  assign side_o  = side_q;

endmodule

FILE: sv/pft_dot.sv
// ----------------------------------------------------------------------------
// pft_dot
// Rounded dot product round((a*c +/- b*d) / 2^30), three stages: split
// partial products, sum of halves, recombine and round half up.
// ----------------------------------------------------------------------------
module pft_dot #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [POSITION_WIDTH:0]        a_i,
  input  logic signed [POSITION_WIDTH:0]        b_i,
  input  logic signed [pft_pkg::COEF_W-1:0]     c_i,
  input  logic signed [pft_pkg::COEF_W-1:0]     d_i,
  input  logic                                  sub_i,
  output logic signed [POSITION_WIDTH+2:0]      r_o
);

  localparam int OP_W  = POSITION_WIDTH + 1;
  localparam int H     = (POSITION_WIDTH + 2) / 2;
  localparam int HI_W  = OP_W - H;
  localparam int LO_W  = H + 1;
  localparam int PLO_W = LO_W + pft_pkg::COEF_W;
  localparam int PHI_W = HI_W + pft_pkg::COEF_W;
  localparam int SLO_W = PLO_W + 1;
  localparam int SHI_W = PHI_W + 1;
  localparam int SW    = POSITION_WIDTH + 36;
  localparam int R_W   = POSITION_WIDTH + 3;

  logic signed [LO_W-1:0]  a_lo, b_lo;
  logic signed [HI_W-1:0]  a_hi, b_hi;
  logic signed [PLO_W-1:0] ac_lo_q, bd_lo_q;
  logic signed [PHI_W-1:0] ac_hi_q, bd_hi_q;
  logic                    sub_q;
  logic signed [SLO_W-1:0] lo_q;
  logic signed [SHI_W-1:0] hi_q;
  logic signed [SW-1:0]    full;
  logic signed [R_W-1:0]   r_q;

  // low half taken unsigned, high half carries the sign
  assign a_lo = {1'b0, a_i[H-1:0]};
  assign b_lo = {1'b0, b_i[H-1:0]};
  assign a_hi = a_i[OP_W-1:H];
  assign b_hi = b_i[OP_W-1:H];

  assign full = (SW'(hi_q) <<< H) + SW'(lo_q) + (SW'(1) <<< 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_lo_q <= a_lo * c_i;
      bd_lo_q <= b_lo * d_i;
      ac_hi_q <= a_hi * c_i;
      bd_hi_q <= b_hi * d_i;
      sub_q   <= sub_i;
      if (sub_q) begin
        lo_q <= SLO_W'(ac_lo_q) - SLO_W'(bd_lo_q);
        hi_q <= SHI_W'(ac_hi_q) - SHI_W'(bd_hi_q);
      end else begin
        lo_q <= SLO_W'(ac_lo_q) + SLO_W'(bd_lo_q);
        hi_q <= SHI_W'(ac_hi_q) + SHI_W'(bd_hi_q);
      end
      r_q <= full[30 +: R_W];
    end
  end

  assign r_o = r_q;

endmodule

FILE: sv/planar_frame_transform.sv
// ----------------------------------------------------------------------------
// planar_frame_transform
// Moves a planar position and heading between a base frame and the world
// frame, with an in-line pipelined cosine/sine rotator.
// ----------------------------------------------------------------------------
// Usage
//   Input channel  : in_valid_i / in_stall_o with func, base pose, position
//                    and heading. An item is taken when valid is high and
//                    stall is low.
//   Output channel : out_valid_o / out_stall_i with out_x, out_y, out_heading
//                    and saturated.
//   Throughput     : one item per cycle, sustained while out_stall_i stays low.
//   Path           : from acceptance to out_valid_o an item passes the input
//                    stage, the row of rotator cells (one micro-rotation per
//                    cell), the three-stage rounded dot product and the
//                    output register.
//   Stall          : the output register holds its item while out_stall_i is
//                    high; one more item lands in a skid register, and only
//                    then is in_stall_o raised and the whole pipe frozen.
//   Reset          : rst_ni clears every valid bit; the pipe comes up empty
//                    and accepting. Datapath registers are not reset.
// ----------------------------------------------------------------------------
module planar_frame_transform #(
  parameter int POSITION_WIDTH  = 32,
  parameter int ANGLE_WIDTH     = 16,
  parameter int ROTATION_STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic signed [POSITION_WIDTH-1:0]  base_x_i,
  input  logic signed [POSITION_WIDTH-1:0]  base_y_i,
  input  logic        [ANGLE_WIDTH-1:0]     base_heading_i,
  input  logic signed [POSITION_WIDTH-1:0]  in_x_i,
  input  logic signed [POSITION_WIDTH-1:0]  in_y_i,
  input  logic        [ANGLE_WIDTH-1:0]     in_heading_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [POSITION_WIDTH-1:0]  out_x_o,
  output logic signed [POSITION_WIDTH-1:0]  out_y_o,
  output logic        [ANGLE_WIDTH-1:0]     out_heading_o,
  output logic                              saturated_o
);

  localparam int PW    = POSITION_WIDTH;
  localparam int AW    = ANGLE_WIDTH;
  localparam int OP_W  = PW + 1;   // exact difference of two positions
  localparam int R_W   = PW + 3;   // rounded rotated coordinate
  localparam int SUM_W = PW + 4;   // after the base offset is added
  localparam int NCELL = (ROTATION_STAGES < pft_pkg::ATAN_LEN) ?
                         ROTATION_STAGES : pft_pkg::ATAN_LEN;

  // Side data that rides alongside the rotator
  typedef struct packed {
    logic                   func;
    logic signed [PW-1:0]   bx;
    logic signed [PW-1:0]   by;
    logic signed [OP_W-1:0] ax;
    logic signed [OP_W-1:0] ay;
    logic [AW-1:0]          heading;
  } side_t;

  // What is left of it after the multipliers
  typedef struct packed {
    logic                 func;
    logic signed [PW-1:0] bx;
    logic signed [PW-1:0] by;
    logic [AW-1:0]        heading;
  } tail_t;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic [AW-1:0]        heading;
    logic                 sat;
  } res_t;

  localparam int SIDE_W = $bits(side_t);

  logic en;

  // ---------------------------------------------------------------------------
  // Input stage: fold the angle into quadrants I/IV, form the operands
  // ---------------------------------------------------------------------------
  logic [pft_pkg::TURN_W-1:0] ang;
  logic                       fold;
  pft_pkg::rot_t              rot0_d, rot0_q;
  side_t                      side0_d, side0_q;
  logic                       v0_q;
  logic                       inverse;

  assign inverse = (func_i == pft_pkg::FUNC_WORLD_TO_LOCAL);
  assign ang     = {base_heading_i, {(pft_pkg::TURN_W-AW){1'b0}}};
  // second or third quadrant: start from the negated vector, half a turn on
  assign fold    = ang[pft_pkg::TURN_W-1] ^ ang[pft_pkg::TURN_W-2];

  always_comb begin
    rot0_d.x = fold ? -pft_pkg::INV_GAIN : pft_pkg::INV_GAIN;
    rot0_d.y = '0;
    rot0_d.z = {ang[pft_pkg::TURN_W-1] ^ fold, ang[pft_pkg::TURN_W-2:0]};

    side0_d.func = func_i;
    side0_d.bx   = base_x_i;
    side0_d.by   = base_y_i;
    if (inverse) begin
      side0_d.ax      = OP_W'(in_x_i) - OP_W'(base_x_i);
      side0_d.ay      = OP_W'(in_y_i) - OP_W'(base_y_i);
      side0_d.heading = in_heading_i - base_heading_i;
    end else begin
      side0_d.ax      = OP_W'(in_x_i);
      side0_d.ay      = OP_W'(in_y_i);
      side0_d.heading = in_heading_i + base_heading_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot0_q  <= rot0_d;
      side0_q <= side0_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Rotator: a row of cells, one micro-rotation each
  // ---------------------------------------------------------------------------
  logic                v_w    [NCELL+1];
  pft_pkg::rot_t       rot_w  [NCELL+1];
  logic [SIDE_W-1:0]   side_w [NCELL+1];

  assign v_w[0]    = v0_q;
  assign rot_w[0]  = rot0_q;
  assign side_w[0] = side0_q;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    pft_cordic_cell #(
      .IDX    (i),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_w[i]),
      .rot_i   (rot_w[i]),
      .side_i  (side_w[i]),
      .valid_o (v_w[i+1]),
      .rot_o   (rot_w[i+1]),
      .side_o  (side_w[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Rotation of the position by the cos/sin pair
  // ---------------------------------------------------------------------------
  side_t                             side_e;
  logic signed [pft_pkg::COEF_W-1:0] cos_v, sin_v;
  logic                              inv_e;
  logic signed [R_W-1:0]             rx, ry;

  assign side_e = side_t'(side_w[NCELL]);
  assign cos_v  = rot_w[NCELL].x[pft_pkg::COEF_W-1:0];
  assign sin_v  = rot_w[NCELL].y[pft_pkg::COEF_W-1:0];
  assign inv_e  = (side_e.func == pft_pkg::FUNC_WORLD_TO_LOCAL);

  // x: ax*c - ay*s forward, ax*c + ay*s inverse
  pft_dot #(.POSITION_WIDTH(PW)) u_dot_x (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (side_e.ax),
    .b_i   (side_e.ay),
    .c_i   (cos_v),
    .d_i   (sin_v),
    .sub_i (!inv_e),
    .r_o   (rx)
  );

  // y: ay*c + ax*s forward, ay*c - ax*s inverse
  pft_dot #(.POSITION_WIDTH(PW)) u_dot_y (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (side_e.ay),
    .b_i   (side_e.ax),
    .c_i   (cos_v),
    .d_i   (sin_v),
    .sub_i (inv_e),
    .r_o   (ry)
  );

  // side data delay matching the dot product unit
  logic  v_dl_q [pft_pkg::DOT_LAT];
  tail_t t_dl_q [pft_pkg::DOT_LAT];
  tail_t tail_in;

  always_comb begin
    tail_in.func    = side_e.func;
    tail_in.bx      = side_e.bx;
    tail_in.by      = side_e.by;
    tail_in.heading = side_e.heading;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pft_pkg::DOT_LAT; k++) begin
        v_dl_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_dl_q[0] <= v_w[NCELL];
      for (int k = 1; k < pft_pkg::DOT_LAT; k++) begin
        v_dl_q[k] <= v_dl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_dl_q[0] <= tail_in;
      for (int k = 1; k < pft_pkg::DOT_LAT; k++) begin
        t_dl_q[k] <= t_dl_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Base offset and clipping
  // ---------------------------------------------------------------------------
  tail_t                 t_e;
  logic                  v_e;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic                  ovf_x, ovf_y;
  res_t                  res;

  assign t_e = t_dl_q[pft_pkg::DOT_LAT-1];
  assign v_e = v_dl_q[pft_pkg::DOT_LAT-1];

  always_comb begin
    if (t_e.func == pft_pkg::FUNC_LOCAL_TO_WORLD) begin
      sum_x = SUM_W'(rx) + SUM_W'(t_e.bx);
      sum_y = SUM_W'(ry) + SUM_W'(t_e.by);
    end else begin
      sum_x = SUM_W'(rx);
      sum_y = SUM_W'(ry);
    end
    // in range when every bit above the sign of a PW-bit word agrees
    ovf_x = !((&sum_x[SUM_W-1:PW-1]) || !(|sum_x[SUM_W-1:PW-1]));
    ovf_y = !((&sum_y[SUM_W-1:PW-1]) || !(|sum_y[SUM_W-1:PW-1]));

    if (ovf_x) begin
      res.x = sum_x[SUM_W-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      res.x = sum_x[PW-1:0];
    end
    if (ovf_y) begin
      res.y = sum_y[SUM_W-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      res.y = sum_y[PW-1:0];
    end
    res.heading = t_e.heading;
    res.sat     = ovf_x || ovf_y;
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid register; the pipe freezes only when the skid
  // is occupied
  // ---------------------------------------------------------------------------
  logic out_v_q, skid_v_q, out_take;
  res_t out_q, skid_q;

  assign en       = !skid_v_q;
  assign out_take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_take) begin
        skid_v_q <= 1'b0;
      end
    end else if (v_e) begin
      if (out_v_q && !out_take) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (v_e) begin
      if (out_v_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o    = skid_v_q;
  assign out_valid_o   = out_v_q;
  assign out_x_o       = out_q.x;
  assign out_y_o       = out_q.y;
  assign out_heading_o = out_q.heading;
  assign saturated_o   = out_q.sat;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an item in the skid always has one ahead of it in the output register
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds an item while the output register is empty");

  // the skid fills only when the receiver held off the output
  a_skid_fill_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid filled without an output stall");

  // a stalled skid keeps its item
  a_skid_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_stall_i |=> skid_v_q)
    else $error("skid item lost during stall");

  // a clipped result sits at one of the range limits
  a_sat_extreme : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.sat |->
      (out_q.x == {1'b0, {(PW-1){1'b1}}}) || (out_q.x == {1'b1, {(PW-1){1'b0}}}) ||
      (out_q.y == {1'b0, {(PW-1){1'b1}}}) || (out_q.y == {1'b1, {(PW-1){1'b0}}}))
    else $error("saturated flag set on an unclipped result");

endmodule
